@@ src/burst_cooldown_duty_controller_assert.svh @@
// ----------------------------------------------------------------------------
// burst_cooldown_duty_controller_assert.svh
// Assertion macros for the burst / cool-down duty controller.
// ----------------------------------------------------------------------------
`ifndef BURST_COOLDOWN_DUTY_CONTROLLER_ASSERT_SVH
`define BURST_COOLDOWN_DUTY_CONTROLLER_ASSERT_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define BCDC_ASSERT_HOLDS(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("bcdc: same-cycle check failed");
// next-cycle implication
`define BCDC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("bcdc: next-cycle check failed");
`else
`define BCDC_ASSERT_HOLDS(lbl, clk, rst_n, ante, cons)
`define BCDC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

@@ src/bcdc_pkg.sv @@
// ----------------------------------------------------------------------------
// bcdc_pkg
// Types and constants of the burst / cool-down duty controller.
// ----------------------------------------------------------------------------
package bcdc_pkg;

	localparam int COUNTER_BITS_DEF = 32;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV_SAMPLE,
		ST_SUM,
		ST_DIV_EMA,
		ST_DONE
	} bcdc_state_t;

	typedef enum logic [1:0] {
		PROF_EXACT = 2'd0,
		PROF_BURST = 2'd1,
		PROF_COOL  = 2'd2
	} bcdc_profile_t;

	typedef enum logic [2:0] {
		REG_ENABLE             = 3'd0,
		REG_COOLDOWN_PERIOD    = 3'd1,
		REG_ACCEPT_FLOOR       = 3'd2,
		REG_MARGIN_FLOOR       = 3'd3,
		REG_BURST_LAYER_LIMIT  = 3'd4,
		REG_BURST_COARSE_ONLY  = 3'd5,
		REG_BURST_EXPERT_COUNT = 3'd6,
		REG_BURST_SKIP_RATIO   = 3'd7
	} bcdc_reg_t;

	localparam logic [16:0] EMA_ONE        = 17'h10000;
	localparam logic [7:0]  EMA_DIVISOR    = 8'd10;
	// floor(x / 10) == (x * EMA_RECIP) >> 23 for every x below 2^22
	localparam logic [19:0] EMA_RECIP      = 20'd838861;
	localparam logic [8:0]  FULL_DIAL      = 9'h1FF;
	localparam logic [15:0] PERIOD_RESET   = 16'd8;
	localparam logic [15:0] STEPS_MAX      = 16'hFFFF;
	// divider step count minus one: 16 quotient bits for the ratio
	localparam logic [4:0]  SAMPLE_STEPS   = 5'd15;

endpackage

@@ src/burst_cooldown_duty_controller.sv @@
// ----------------------------------------------------------------------------
// burst_cooldown_duty_controller
// Picks a compute profile (exact, burst, cool-down) per decode step and keeps
// a Q1.16 draft-acceptance EMA. Each request on the input stream gives one
// result. A decide request goes from ST_IDLE to ST_DONE and then into the
// output register; a feed request runs one shared restoring divider (one
// quotient bit per cycle) that forms accepted/drafted in 16 steps; when
// drafted is zero or accepted >= drafted the divider is skipped. 9*ema +
// sample is then summed in ST_SUM and divided by ten with a reciprocal
// multiply in ST_DIV_EMA. A stalled result stream holds the block in
// ST_DONE. s_tready is low while a request is in work; the output
// register lets the next request in once the block is idle even if the
// previous result has not been taken. Registers sit behind an APB port at
// byte address 4*index, 32-bit data, pready tied high.
// ----------------------------------------------------------------------------
`include "burst_cooldown_duty_controller_assert.svh"

module burst_cooldown_duty_controller
	import bcdc_pkg::*;
#(
	parameter int COUNTER_BITS = COUNTER_BITS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	// input stream
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [31:0]  s_tdata,   // margin[15:0], accepted[23:16], drafted[31:24]
	input  logic         s_tuser,   // kind (0 decide, 1 feed)
	// result stream
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [119:0] m_tdata,   // profile[1:0], layer_limit[10:2], use_fine_tier[11],
	                                // expert_count[20:12], skip_ratio[36:21],
	                                // accept_rate[53:37], burst_total[85:54],
	                                // cooldown_total[117:86], zero[119:118]
	// configuration
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [4:0]   paddr,
	input  logic [31:0]  pwdata,
	output logic [31:0]  prdata,
	output logic         pready
);

	// configuration registers
	logic               enable_q;
	logic [15:0]        cooldown_period_q;
	logic [16:0]        accept_floor_q;
	logic [14:0]        margin_floor_q;
	logic [8:0]         burst_layer_limit_q;
	logic               burst_coarse_only_q;
	logic [8:0]         burst_expert_count_q;
	logic [15:0]        burst_skip_ratio_q;

	// controller state
	bcdc_state_t        state_q, state_d;
	bcdc_profile_t      prof_q;
	logic [16:0]        ema_q;
	logic [15:0]        steps_q;
	logic [COUNTER_BITS-1:0] burst_cnt_q;
	logic [COUNTER_BITS-1:0] cool_cnt_q;
	logic [16:0]        sample_q;

	// shared divider
	logic [7:0]         rem_q;
	logic [19:0]        dq_q;
	logic [7:0]         div_q;
	logic [4:0]         cnt_q;
	logic [8:0]         trial;
	logic               ge;
	logic [7:0]         rem_step;
	logic [19:0]        dq_step;
	logic               div_last;

	// output register
	logic               m_valid_q;
	logic [119:0]       m_data_q;

	logic               in_acc;
	logic               out_free;
	logic               out_load;
	logic               cfg_wr;
	logic signed [15:0] margin;
	logic [7:0]         accepted;
	logic [7:0]         drafted;
	logic               go_cool;
	logic               need_div;
	logic [19:0]        ema_sum;
	logic [39:0]        ema_prod;
	logic [63:0]        burst_ext;
	logic [63:0]        cool_ext;
	logic [8:0]         o_layer;
	logic               o_fine;
	logic [8:0]         o_expert;
	logic [15:0]        o_skip;

	assign margin   = $signed(s_tdata[15:0]);
	assign accepted = s_tdata[23:16];
	assign drafted  = s_tdata[31:24];

	assign s_tready = (state_q == ST_IDLE);
	assign in_acc   = s_tvalid && s_tready;
	assign out_free = !m_valid_q || m_tready;
	assign out_load = (state_q == ST_DONE) && out_free;
	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;

	// ---------------- configuration port ----------------
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q             <= 1'b0;
			cooldown_period_q    <= PERIOD_RESET;
			accept_floor_q       <= '0;
			margin_floor_q       <= '0;
			burst_layer_limit_q  <= FULL_DIAL;
			burst_coarse_only_q  <= 1'b0;
			burst_expert_count_q <= FULL_DIAL;
			burst_skip_ratio_q   <= '0;
		end else if (cfg_wr) begin
			case (bcdc_reg_t'(paddr[4:2]))
				REG_ENABLE:             enable_q             <= pwdata[0];
				REG_COOLDOWN_PERIOD:    cooldown_period_q    <= pwdata[15:0];
				REG_ACCEPT_FLOOR:       accept_floor_q       <= pwdata[16:0];
				REG_MARGIN_FLOOR:       margin_floor_q       <= pwdata[14:0];
				REG_BURST_LAYER_LIMIT:  burst_layer_limit_q  <= pwdata[8:0];
				REG_BURST_COARSE_ONLY:  burst_coarse_only_q  <= pwdata[0];
				REG_BURST_EXPERT_COUNT: burst_expert_count_q <= pwdata[8:0];
				REG_BURST_SKIP_RATIO:   burst_skip_ratio_q   <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (bcdc_reg_t'(paddr[4:2]))
			REG_ENABLE:             prdata = 32'(enable_q);
			REG_COOLDOWN_PERIOD:    prdata = 32'(cooldown_period_q);
			REG_ACCEPT_FLOOR:       prdata = 32'(accept_floor_q);
			REG_MARGIN_FLOOR:       prdata = 32'(margin_floor_q);
			REG_BURST_LAYER_LIMIT:  prdata = 32'(burst_layer_limit_q);
			REG_BURST_COARSE_ONLY:  prdata = 32'(burst_coarse_only_q);
			REG_BURST_EXPERT_COUNT: prdata = 32'(burst_expert_count_q);
			REG_BURST_SKIP_RATIO:   prdata = 32'(burst_skip_ratio_q);
			default:                prdata = '0;
		endcase
	end

	// ---------------- decide rule ----------------
	assign go_cool = ((cooldown_period_q != '0) && (steps_q >= cooldown_period_q)) ||
	                 ((accept_floor_q != '0) && (ema_q < accept_floor_q)) ||
	                 ((margin_floor_q != '0) &&
	                  (margin < $signed({1'b0, margin_floor_q})));

	// only a true fraction needs the divider
	assign need_div = (drafted != '0) && (accepted < drafted);

	// ---------------- shared divider step ----------------
	assign trial    = {rem_q, dq_q[19]};
	assign ge       = trial >= {1'b0, div_q};
	assign rem_step = ge ? 8'(trial - {1'b0, div_q}) : trial[7:0];
	assign dq_step  = {dq_q[18:0], ge};
	assign div_last = (cnt_q == '0);

	assign ema_sum  = {ema_q, 3'b000} + 20'(ema_q) + 20'(sample_q);
	// divide by ten: the registered sum is at most 10 * 1.0, well inside the range
	assign ema_prod = 40'(dq_q) * 40'(EMA_RECIP);

	// ---------------- sequencer ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					if (!s_tuser)
						state_d = ST_DONE;
					else if (need_div)
						state_d = ST_DIV_SAMPLE;
					else
						state_d = ST_SUM;
				end
			end
			ST_DIV_SAMPLE: begin
				if (div_last)
					state_d = ST_SUM;
			end
			ST_SUM:        state_d = ST_DIV_EMA;
			ST_DIV_EMA:    state_d = ST_DONE;
			ST_DONE: begin
				if (out_free)
					state_d = ST_IDLE;
			end
			default:       state_d = ST_IDLE;
		endcase
	end

	// ---------------- datapath ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prof_q      <= PROF_EXACT;
			ema_q       <= EMA_ONE;
			steps_q     <= '0;
			burst_cnt_q <= '0;
			cool_cnt_q  <= '0;
			cnt_q       <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_acc && !s_tuser) begin
						if (!enable_q) begin
							prof_q <= PROF_EXACT;
						end else if (go_cool) begin
							prof_q     <= PROF_COOL;
							steps_q    <= '0;
							cool_cnt_q <= cool_cnt_q + 1'b1;
						end else begin
							prof_q      <= PROF_BURST;
							burst_cnt_q <= burst_cnt_q + 1'b1;
							if (steps_q != STEPS_MAX)
								steps_q <= steps_q + 1'b1;
						end
					end else if (in_acc) begin
						cnt_q <= SAMPLE_STEPS;
					end
				end
				ST_DIV_SAMPLE: cnt_q <= cnt_q - 1'b1;
				ST_DIV_EMA:    ema_q <= ema_prod[39:23];
				default: ;
			endcase
		end
	end

	// divider operands and sample carry no reset
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (in_acc && s_tuser) begin
					rem_q <= accepted;
					dq_q  <= '0;
					div_q <= drafted;
					if (drafted == '0)
						sample_q <= ema_q;   // no draft: sample is the old EMA
					else
						sample_q <= EMA_ONE; // saturated ratio
				end
			end
			ST_DIV_SAMPLE: begin
				rem_q <= rem_step;
				dq_q  <= dq_step;
				if (div_last)
					sample_q <= {1'b0, dq_step[15:0]};
			end
			ST_SUM:        dq_q <= ema_sum;
			default: ;
		endcase
	end

	// ---------------- result register ----------------
	assign burst_ext = 64'(burst_cnt_q);
	assign cool_ext  = 64'(cool_cnt_q);

	always_comb begin
		if (prof_q == PROF_BURST) begin
			o_layer  = burst_layer_limit_q;
			o_fine   = !burst_coarse_only_q;
			o_expert = burst_expert_count_q;
			o_skip   = burst_skip_ratio_q;
		end else begin
			o_layer  = FULL_DIAL;
			o_fine   = 1'b1;
			o_expert = FULL_DIAL;
			o_skip   = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			m_valid_q <= 1'b0;
		else if (out_load)
			m_valid_q <= 1'b1;
		else if (m_tready)
			m_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (out_load)
			m_data_q <= {2'b00, cool_ext[31:0], burst_ext[31:0], ema_q, o_skip,
			             o_expert, o_fine, o_layer, prof_q};
	end

	// ---------------- checks ----------------
	`BCDC_ASSERT_HOLDS(a_ema_range, clk, arst_n, 1'b1, ema_q <= EMA_ONE)
	`BCDC_ASSERT_HOLDS(a_rem_below_div, clk, arst_n, state_q == ST_DIV_SAMPLE, rem_q < div_q)
	`BCDC_ASSERT_HOLDS(a_cool_clears_steps, clk, arst_n, prof_q == PROF_COOL, steps_q == '0)
	`BCDC_ASSERT_NEXT(a_busy_after_accept, clk, arst_n, in_acc, !s_tready)

endmodule

@@ tb/burst_cooldown_duty_controller_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// burst_cooldown_duty_controller_test
// Self-checking bench for the burst / cool-down duty controller. A queue of
// decide and feed requests drives the input stream with random gaps, a
// behavioral copy of the controller predicts the profile dials and metrics of
// every accepted request, and the result stream (with random stalls) is
// compared field by field. Registers are rewritten over APB between phases.
// ----------------------------------------------------------------------------
module burst_cooldown_duty_controller_test;
	import bcdc_pkg::*;

	localparam logic KIND_DECIDE = 1'b0;
	localparam logic KIND_FEED = 1'b1;
	localparam int WATCHDOG_LIMIT = 3000;
	localparam int RANDOM_PHASES = 8;
	localparam int PHASE_STEPS = 160;
	localparam int LONG_RUN = 40;

	typedef struct {
		logic        kind;
		logic [15:0] margin;
		logic [7:0]  accepted;
		logic [7:0]  drafted;
	} duty_req_t;

	// m_tdata[117:0], highest field first
	typedef struct packed {
		logic [31:0] cooldown_total;
		logic [31:0] burst_total;
		logic [16:0] accept_rate;
		logic [15:0] skip_ratio;
		logic [8:0]  expert_count;
		logic        use_fine_tier;
		logic [8:0]  layer_limit;
		logic [1:0]  profile;
	} duty_result_t;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         s_tvalid = 1'b0;
	logic         s_tready;
	logic [31:0]  s_tdata = '0;   // margin[15:0], accepted[23:16], drafted[31:24]
	logic         s_tuser = 1'b0; // kind (0 decide, 1 feed)
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	logic [119:0] m_tdata;        // profile, layer_limit, use_fine_tier, expert_count,
	                              // skip_ratio, accept_rate, burst_total, cooldown_total
	logic         psel = 1'b0;
	logic         penable = 1'b0;
	logic         pwrite = 1'b0;
	logic [4:0]   paddr = '0;
	logic [31:0]  pwdata = '0;
	logic [31:0]  prdata;
	logic         pready;

	burst_cooldown_duty_controller dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	// controller copy: registers
	logic        cfg_enable = 1'b0;
	logic [15:0] cfg_period = PERIOD_RESET;
	logic [16:0] cfg_accept_floor = '0;
	logic [14:0] cfg_margin_floor = '0;
	logic [8:0]  cfg_layer_limit = FULL_DIAL;
	logic        cfg_coarse_only = 1'b0;
	logic [8:0]  cfg_expert_count = FULL_DIAL;
	logic [15:0] cfg_skip_ratio = '0;

	// controller copy: state
	logic [16:0]   pred_ema = EMA_ONE;
	logic [15:0]   steps_since_cool = '0;
	logic [31:0]   pred_bursts = '0;
	logic [31:0]   cool_steps = '0;
	bcdc_profile_t pred_profile = PROF_EXACT;

	duty_req_t    pending_steps[$];
	duty_result_t due_profiles[$];
	duty_req_t    cur_req;
	duty_result_t seen_res;
	duty_result_t want_res;
	int           mismatches = 0;
	int           send_gap = 0;
	int           stall_left = 0;
	int           quiet_cycles = 0;
	bit           idle_on = 1'b1;

	initial begin
		forever #1 clk = ~clk;
	end

	function automatic duty_result_t advance_controller(input duty_req_t r);
		duty_result_t res;
		int unsigned  sample;
		logic         cool_now;
		if (r.kind == KIND_DECIDE) begin
			if (!cfg_enable) begin
				pred_profile = PROF_EXACT;
			end else begin
				cool_now = (cfg_period != 0 && steps_since_cool >= cfg_period) ||
					(cfg_accept_floor != 0 && pred_ema < cfg_accept_floor) ||
					(cfg_margin_floor != 0 &&
					 $signed(r.margin) < $signed({1'b0, cfg_margin_floor}));
				if (cool_now) begin
					steps_since_cool = '0;
					cool_steps = cool_steps + 1;
					pred_profile = PROF_COOL;
				end else begin
					if (steps_since_cool != STEPS_MAX)
						steps_since_cool = steps_since_cool + 1;
					pred_bursts = pred_bursts + 1;
					pred_profile = PROF_BURST;
				end
			end
		end else begin
			if (r.drafted != 0) begin
				sample = (32'(r.accepted) << 16) / 32'(r.drafted);
				if (sample > EMA_ONE)
					sample = EMA_ONE;
			end else begin
				sample = 32'(pred_ema);
			end
			pred_ema = 17'(((32'(EMA_DIVISOR) - 1) * 32'(pred_ema) + sample) /
				32'(EMA_DIVISOR));
		end
		res.profile = pred_profile;
		if (pred_profile == PROF_BURST) begin
			res.layer_limit = cfg_layer_limit;
			res.use_fine_tier = ~cfg_coarse_only;
			res.expert_count = cfg_expert_count;
			res.skip_ratio = cfg_skip_ratio;
		end else begin
			res.layer_limit = FULL_DIAL;
			res.use_fine_tier = 1'b1;
			res.expert_count = FULL_DIAL;
			res.skip_ratio = '0;
		end
		res.accept_rate = pred_ema;
		res.burst_total = pred_bursts;
		res.cooldown_total = cool_steps;
		return res;
	endfunction

	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic void check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			mismatches++;
			if (mismatches <= 10)
				$display("mismatch on %s: expected %0h, got %0h", name, want, got);
		end
	endfunction

	// request driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
			s_tuser <= 1'b0;
			send_gap <= 0;
		end else begin
			if (s_tvalid && s_tready)
				due_profiles.push_back(advance_controller(cur_req));
			if (!s_tvalid || s_tready) begin
				if (send_gap != 0) begin
					send_gap <= send_gap - 1;
					s_tvalid <= 1'b0;
				end else if (pending_steps.size() != 0) begin
					cur_req = pending_steps.pop_front();
					s_tvalid <= 1'b1;
					s_tdata <= {cur_req.drafted, cur_req.accepted, cur_req.margin};
					s_tuser <= cur_req.kind;
					send_gap <= idle_on ? gap_len() : 0;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// result monitor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
			stall_left <= 0;
		end else begin
			if (m_tvalid && m_tready) begin
				seen_res = m_tdata[117:0];
				if (due_profiles.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected result %0h", m_tdata);
				end else begin
					want_res = due_profiles.pop_front();
					check_field("profile", want_res.profile, seen_res.profile);
					check_field("layer_limit", want_res.layer_limit, seen_res.layer_limit);
					check_field("use_fine_tier", want_res.use_fine_tier,
						seen_res.use_fine_tier);
					check_field("expert_count", want_res.expert_count,
						seen_res.expert_count);
					check_field("skip_ratio", want_res.skip_ratio, seen_res.skip_ratio);
					check_field("accept_rate", want_res.accept_rate, seen_res.accept_rate);
					check_field("burst_total", want_res.burst_total, seen_res.burst_total);
					check_field("cooldown_total", want_res.cooldown_total,
						seen_res.cooldown_total);
				end
			end
			if (stall_left != 0) begin
				stall_left <= stall_left - 1;
				m_tready <= 1'b0;
			end else if (idle_on && $urandom_range(0, 3) == 0) begin
				stall_left <= gap_len();
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) || psel) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles == WATCHDOG_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	task automatic write_reg(input bcdc_reg_t idx, input logic [31:0] value);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			REG_ENABLE:             cfg_enable = value[0];
			REG_COOLDOWN_PERIOD:    cfg_period = value[15:0];
			REG_ACCEPT_FLOOR:       cfg_accept_floor = value[16:0];
			REG_MARGIN_FLOOR:       cfg_margin_floor = value[14:0];
			REG_BURST_LAYER_LIMIT:  cfg_layer_limit = value[8:0];
			REG_BURST_COARSE_ONLY:  cfg_coarse_only = value[0];
			REG_BURST_EXPERT_COUNT: cfg_expert_count = value[8:0];
			REG_BURST_SKIP_RATIO:   cfg_skip_ratio = value[15:0];
			default: ;
		endcase
	endtask

	task automatic set_config(input logic en, input logic [15:0] period,
			input logic [16:0] afloor, input logic [14:0] mfloor, input logic [8:0] layer,
			input logic coarse, input logic [8:0] experts, input logic [15:0] skip);
		write_reg(REG_ENABLE, 32'(en));
		write_reg(REG_COOLDOWN_PERIOD, 32'(period));
		write_reg(REG_ACCEPT_FLOOR, 32'(afloor));
		write_reg(REG_MARGIN_FLOOR, 32'(mfloor));
		write_reg(REG_BURST_LAYER_LIMIT, 32'(layer));
		write_reg(REG_BURST_COARSE_ONLY, 32'(coarse));
		write_reg(REG_BURST_EXPERT_COUNT, 32'(experts));
		write_reg(REG_BURST_SKIP_RATIO, 32'(skip));
		@(negedge clk);
	endtask

	function automatic void push_decide(input logic [15:0] margin);
		duty_req_t r;
		r.kind = KIND_DECIDE;
		r.margin = margin;
		r.accepted = 8'($urandom);
		r.drafted = 8'($urandom);
		pending_steps.push_back(r);
	endfunction

	function automatic void push_feed(input logic [7:0] accepted, input logic [7:0] drafted);
		duty_req_t r;
		r.kind = KIND_FEED;
		r.margin = 16'($urandom);
		r.accepted = accepted;
		r.drafted = drafted;
		pending_steps.push_back(r);
	endfunction

	// wait at the falling edge so the driver's queue pop has settled
	task automatic drain();
		do
			@(negedge clk);
		while (pending_steps.size() != 0 || s_tvalid || due_profiles.size() != 0);
	endtask

	function automatic logic [8:0] rand_dial();
		case ($urandom_range(0, 3))
			0: return FULL_DIAL;
			1: return 9'd255;
			2: return 9'd0;
			default: return 9'($urandom_range(0, 254));
		endcase
	endfunction

	task automatic random_config();
		logic [15:0] period;
		logic [16:0] afloor;
		logic [14:0] mfloor;
		logic [15:0] skip;
		case ($urandom_range(0, 5))
			0: period = '0;
			1: period = 16'd1;
			2: period = STEPS_MAX;
			default: period = 16'($urandom_range(2, 12));
		endcase
		case ($urandom_range(0, 7))
			0, 1: afloor = '0;
			2: afloor = EMA_ONE;
			3: afloor = 17'h1FFFF;
			4: afloor = 17'($urandom_range(0, 131071));
			default: afloor = 17'($urandom_range(20000, 65536));
		endcase
		case ($urandom_range(0, 5))
			0: mfloor = '0;
			1: mfloor = 15'h7FFF;
			2: mfloor = 15'd1;
			3: mfloor = 15'($urandom);
			default: mfloor = 15'($urandom_range(1, 2048));
		endcase
		case ($urandom_range(0, 3))
			0: skip = '0;
			1: skip = 16'hFFFF;
			default: skip = 16'($urandom);
		endcase
		set_config($urandom_range(0, 5) != 0, period, afloor, mfloor, rand_dial(),
			1'($urandom), rand_dial(), skip);
	endtask

	task automatic random_steps(input int count);
		int          d;
		logic [15:0] m;
		for (int i = 0; i < count; i++) begin
			if ($urandom_range(0, 1) == 0) begin
				case ($urandom_range(0, 3))
					0: m = 16'($urandom);
					1: m = {1'b0, cfg_margin_floor} + 16'($urandom_range(0, 4)) - 16'd2;
					2: m = $urandom_range(0, 1) ? 16'h8000 : 16'h7FFF;
					default: m = 16'($urandom_range(0, 4096));
				endcase
				push_decide(m);
			end else begin
				case ($urandom_range(0, 9))
					0: push_feed(8'($urandom), 8'd0);
					1: begin
						d = $urandom_range(0, 254);
						push_feed(8'($urandom_range(d + 1, 255)), 8'(d));
					end
					default: begin
						d = $urandom_range(1, 255);
						push_feed(8'($urandom_range(0, d)), 8'(d));
					end
				endcase
			end
		end
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// disabled out of reset: exact profile, counters idle
		push_decide(16'h8000);
		push_feed(8'd5, 8'd10);
		push_decide(16'h7FFF);
		drain();

		set_config(1'b1, 16'd3, 17'd0, 15'd256, 9'd5, 1'b1, 9'd0, 16'hFFFF);
		push_decide(16'h7FFF);
		push_decide(16'h8000);
		push_decide(16'd255);
		push_decide(16'd256);
		push_decide(16'd256);
		push_decide(16'd256);
		push_decide(16'h7FFF);          // period reached
		push_feed(8'd255, 8'd255);
		push_feed(8'd0, 8'd255);
		push_feed(8'd255, 8'd0);        // nothing drafted
		push_feed(8'd255, 8'd1);        // ratio saturates
		push_feed(8'd1, 8'd3);
		push_feed(8'd0, 8'd0);
		push_feed(8'd200, 8'd100);      // more accepted than drafted
		push_decide(16'd1000);
		drain();

		// floor above 1.0 always forces cool-down
		set_config(1'b1, 16'd0, 17'h1FFFF, 15'd0, 9'd255, 1'b0, 9'd255, 16'd0);
		push_decide(16'd0);
		push_feed(8'd128, 8'd255);
		push_decide(16'h7FFF);
		drain();

		write_reg(REG_ENABLE, 32'd0);
		@(negedge clk);
		push_decide(16'h8000);
		push_feed(8'd3, 8'd7);
		drain();

		// unbroken burst run with the period rule off, then the widest period
		idle_on = 1'b0;
		set_config(1'b1, 16'd0, 17'd0, 15'd0, 9'd255, 1'b0, 9'd255, 16'd0);
		for (int i = 0; i < LONG_RUN; i++)
			push_decide(16'($urandom));
		drain();
		write_reg(REG_COOLDOWN_PERIOD, 32'(STEPS_MAX));
		@(negedge clk);
		push_decide(16'd0);
		push_decide(16'd0);
		drain();

		for (int p = 0; p < RANDOM_PHASES; p++) begin
			idle_on = (p % 4) != 1;
			random_config();
			random_steps(PHASE_STEPS);
			drain();
		end

		repeat (50) @(posedge clk);
		if (mismatches == 0 && due_profiles.size() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
